FILE: sv/crd_pkg.sv
// ----------------------------------------------------------------------------
// crd_pkg: shared types and constants of the clip run detector
// Widths, register indexes, verdict codes, control/status bundles and the
// clamp level function.
// ----------------------------------------------------------------------------
package crd_pkg;

  localparam int MAX_CHANNELS_DEF = 8;

  localparam int SAMPLE_W     = 32;
  localparam int PEAK_HIGH_W  = 31;
  localparam int COUNT_W      = 32;
  localparam int GAIN_W       = 25;
  localparam int VERDICT_W    = 2;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 6;
  localparam int CHAN_CNT_W   = 4;
  localparam int SRC_BITS_W   = 6;

  localparam int DIV_NUM_W    = 49;
  localparam int DIV_DEN_W    = 32;
  localparam int DIV_QUO_W    = 25;
  localparam int DIV_CNT_W    = 5;

  localparam logic [GAIN_W-1:0]      ONE_Q24     = 25'h100_0000;
  localparam logic [SAMPLE_W-1:0]    NEG_ONE_Q24 = 32'hFF00_0000;
  localparam logic [COUNT_W-1:0]     ALL_ONES    = '1;
  localparam logic [DIV_NUM_W-1:0]   TWO_POW_48  = 49'h1_0000_0000_0000;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_BITS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMALIZE_OFF = 2'd2;

  // Verdict codes.
  localparam logic [VERDICT_W-1:0] VERDICT_NONE    = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_INTEGER = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_NORM    = 2'd2;
  localparam logic [VERDICT_W-1:0] VERDICT_GAIN    = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic step;       // sample transfer
    logic cfg_we;     // configuration write
    logic tally;      // add one open run per cycle
    logic div_start;  // launch the divider
    logic div_hi;     // divider works on the high-side term
    logic load;       // fill output register and clear buffer state
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic tally_last;
    logic need_div;
    logic hi_zero;
    logic div_done;
  } sts_t;

  // Clamp level in Q1.24: 1 - 2^-(bits-1) for integer depths 1..23, else 1.0.
  function automatic logic [GAIN_W-1:0] clamp_level(input logic [SRC_BITS_W-1:0] bits);
    logic [GAIN_W-1:0] lvl;
    lvl = ONE_Q24;
    if (bits >= 6'd1 && bits <= 6'd23) begin
      lvl = ONE_Q24 - (GAIN_W'(1) << (5'd25 - bits[4:0]));
    end
    return lvl;
  endfunction

endpackage

FILE: sv/crd_div.sv
// ----------------------------------------------------------------------------
// crd_div: iterative restoring divider
// Produces a 25-bit quotient, one bit per cycle, for dividends whose
// quotient is known to fit in 25 bits.
// ----------------------------------------------------------------------------
module crd_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [crd_pkg::DIV_NUM_W-1:0]      num_i,
  input  logic [crd_pkg::DIV_DEN_W-1:0]      den_i,
  output logic                               done_o,
  output logic [crd_pkg::DIV_QUO_W-1:0]      quo_o
);

  logic                              busy_q;
  logic                              done_q;
  logic [crd_pkg::DIV_CNT_W-1:0]     cnt_q;
  logic [crd_pkg::DIV_DEN_W-1:0]     rem_q;
  logic [crd_pkg::DIV_QUO_W-1:0]     num_q;
  logic [crd_pkg::DIV_DEN_W-1:0]     den_q;
  logic [crd_pkg::DIV_QUO_W-1:0]     quo_q;

  logic [crd_pkg::DIV_DEN_W:0]       shifted;
  logic [crd_pkg::DIV_DEN_W:0]       diff;
  logic                              ge;

  // The remainder stays below the divisor, so one extra bit holds the shift.
  assign shifted = {rem_q, num_q[crd_pkg::DIV_QUO_W-1]};
  assign ge      = shifted >= {1'b0, den_q};
  assign diff    = shifted - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= crd_pkg::DIV_CNT_W'(crd_pkg::DIV_QUO_W - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= crd_pkg::DIV_DEN_W'(num_i[crd_pkg::DIV_NUM_W-1:crd_pkg::DIV_QUO_W]);
      num_q <= num_i[crd_pkg::DIV_QUO_W-1:0];
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[crd_pkg::DIV_DEN_W-1:0] : shifted[crd_pkg::DIV_DEN_W-1:0];
      num_q <= {num_q[crd_pkg::DIV_QUO_W-2:0], 1'b0};
      quo_q <= {quo_q[crd_pkg::DIV_QUO_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

FILE: sv/crd_datapath.sv
// ----------------------------------------------------------------------------
// crd_datapath: run counters, peaks, clip total and gain computation
// Holds the configuration registers and all per-buffer state, and the
// output register of the result channel.
// ----------------------------------------------------------------------------
module crd_datapath #(
  parameter int MAX_CHANNELS = crd_pkg::MAX_CHANNELS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  crd_pkg::cmd_t                        cmd_i,
  output crd_pkg::sts_t                        sts_o,
  input  logic [crd_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [crd_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic signed [crd_pkg::SAMPLE_W-1:0]  sample_i,
  output logic [crd_pkg::COUNT_W-1:0]          clipped_count_o,
  output logic signed [crd_pkg::SAMPLE_W-1:0]  peak_low_o,
  output logic [crd_pkg::PEAK_HIGH_W-1:0]      peak_high_o,
  output logic [crd_pkg::VERDICT_W-1:0]        verdict_o,
  output logic [crd_pkg::GAIN_W-1:0]           gain_o
);

  localparam int PosW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CntW = $clog2(MAX_CHANNELS + 1);

  // Configuration registers.
  logic [crd_pkg::CHAN_CNT_W-1:0]      chan_cnt_q;
  logic [crd_pkg::SRC_BITS_W-1:0]      src_bits_q;
  logic                                norm_off_q;

  // Buffer state.
  logic [crd_pkg::COUNT_W-1:0]         run_q [MAX_CHANNELS];
  logic [PosW-1:0]                     pos_q;
  logic [PosW-1:0]                     idx_q;
  logic [crd_pkg::COUNT_W-1:0]         total_q;
  logic signed [crd_pkg::SAMPLE_W-1:0] low_q;
  logic [crd_pkg::PEAK_HIGH_W-1:0]     high_q;
  logic [crd_pkg::GAIN_W-1:0]          gain_q;

  logic [CntW-1:0]                     act_cnt;
  logic [PosW-1:0]                     pos_eff;
  logic [PosW-1:0]                     pos_next;
  logic [PosW-1:0]                     rd_idx;
  logic [crd_pkg::COUNT_W-1:0]         rd_run;
  logic [crd_pkg::COUNT_W-1:0]         run_inc;
  logic                                run_gt1;
  logic [crd_pkg::COUNT_W:0]           sum;
  logic [crd_pkg::COUNT_W-1:0]         total_sat;
  logic [crd_pkg::GAIN_W-1:0]          clamp;
  logic                                below;
  logic                                above;
  logic                                tally_last;

  logic                                div_done;
  logic [crd_pkg::DIV_QUO_W-1:0]       div_quo;
  logic [crd_pkg::DIV_NUM_W-1:0]       div_num;
  logic [crd_pkg::DIV_DEN_W-1:0]       div_den;
  logic [crd_pkg::GAIN_W-1:0]          gain_cap;

  // A channel count of zero acts as one; counts above the maximum are capped.
  always_comb begin
    if (chan_cnt_q == '0) begin
      act_cnt = CntW'(1);
    end else if (32'(chan_cnt_q) > 32'(MAX_CHANNELS)) begin
      act_cnt = CntW'(MAX_CHANNELS);
    end else begin
      act_cnt = CntW'(chan_cnt_q);
    end
  end

  assign pos_eff    = (32'(pos_q) >= 32'(act_cnt)) ? '0 : pos_q;
  assign pos_next   = (32'(pos_eff) + 32'd1 >= 32'(act_cnt)) ? '0 : pos_eff + 1'b1;
  assign tally_last = (32'(idx_q) + 32'd1 >= 32'(act_cnt));

  // One read port, shared between the sample update and the final tally.
  assign rd_idx    = cmd_i.tally ? idx_q : pos_eff;
  assign rd_run    = run_q[rd_idx];
  assign run_gt1   = rd_run > crd_pkg::COUNT_W'(1);
  assign run_inc   = (rd_run == crd_pkg::ALL_ONES) ? rd_run : rd_run + 1'b1;
  assign sum       = {1'b0, total_q} + {1'b0, rd_run};
  assign total_sat = sum[crd_pkg::COUNT_W] ? crd_pkg::ALL_ONES : sum[crd_pkg::COUNT_W-1:0];

  assign clamp = crd_pkg::clamp_level(src_bits_q);
  assign below = sample_i < $signed(crd_pkg::NEG_ONE_Q24);
  assign above = sample_i > $signed({7'b0, clamp});

  // Low term: 2^48 / -low_peak. High term: (clamp << 24) / high_peak.
  assign div_num = cmd_i.div_hi ? {clamp, 24'b0} : crd_pkg::TWO_POW_48;
  assign div_den = cmd_i.div_hi ? {1'b0, high_q} : (crd_pkg::DIV_DEN_W'(0) - low_q);

  crd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_comb begin
    sts_o            = '0;
    sts_o.tally_last = tally_last;
    sts_o.need_div   = (total_q != '0) && (src_bits_q == '0) && !norm_off_q;
    sts_o.hi_zero    = (high_q == '0);
    sts_o.div_done   = div_done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_cnt_q <= crd_pkg::CHAN_CNT_W'(2);
      src_bits_q <= '0;
      norm_off_q <= 1'b0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        run_q[i] <= '0;
      end
      pos_q   <= '0;
      idx_q   <= '0;
      total_q <= '0;
      low_q   <= $signed(crd_pkg::NEG_ONE_Q24);
      high_q  <= crd_pkg::PEAK_HIGH_W'(crd_pkg::ONE_Q24);
    end else if (cmd_i.cfg_we) begin
      unique case (cfg_index_i)
        crd_pkg::CFG_CHANNEL_COUNT: begin
          chan_cnt_q <= cfg_data_i[crd_pkg::CHAN_CNT_W-1:0];
          for (int i = 0; i < MAX_CHANNELS; i++) begin
            run_q[i] <= '0;
          end
          pos_q <= '0;
        end
        crd_pkg::CFG_SOURCE_BITS: begin
          src_bits_q <= cfg_data_i;
          high_q     <= crd_pkg::PEAK_HIGH_W'(crd_pkg::clamp_level(cfg_data_i));
        end
        crd_pkg::CFG_NORMALIZE_OFF: begin
          norm_off_q <= cfg_data_i[0];
        end
        default: begin
        end
      endcase
    end else if (cmd_i.step) begin
      if (below || above) begin
        run_q[pos_eff] <= run_inc;
        if (below && (sample_i < low_q)) begin
          low_q <= sample_i;
        end
        if (above && (sample_i[crd_pkg::PEAK_HIGH_W-1:0] > high_q)) begin
          high_q <= sample_i[crd_pkg::PEAK_HIGH_W-1:0];
        end
      end else begin
        if (run_gt1) begin
          total_q <= total_sat;
        end
        run_q[pos_eff] <= '0;
      end
      pos_q <= pos_next;
    end else if (cmd_i.tally) begin
      if (run_gt1) begin
        total_q <= total_sat;
      end
      idx_q <= tally_last ? '0 : idx_q + 1'b1;
    end else if (cmd_i.load) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        run_q[i] <= '0;
      end
      pos_q   <= '0;
      total_q <= '0;
      low_q   <= $signed(crd_pkg::NEG_ONE_Q24);
      high_q  <= crd_pkg::PEAK_HIGH_W'(clamp);
    end
  end

  // The gain keeps the smaller of the two terms.
  always_ff @(posedge clk_i) begin
    if (div_done) begin
      if (!cmd_i.div_hi || (div_quo < gain_q)) begin
        gain_q <= div_quo;
      end
    end
  end

  assign gain_cap = (gain_q > crd_pkg::ONE_Q24) ? crd_pkg::ONE_Q24 : gain_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      clipped_count_o <= total_q;
      peak_low_o      <= low_q;
      peak_high_o     <= high_q;
      gain_o          <= crd_pkg::ONE_Q24;
      if (total_q == '0) begin
        verdict_o <= crd_pkg::VERDICT_NONE;
      end else if (src_bits_q != '0) begin
        verdict_o <= crd_pkg::VERDICT_INTEGER;
      end else if (norm_off_q) begin
        verdict_o <= crd_pkg::VERDICT_NORM;
      end else begin
        verdict_o <= crd_pkg::VERDICT_GAIN;
        gain_o    <= gain_cap;
      end
    end
  end

endmodule

FILE: sv/crd_ctrl.sv
// ----------------------------------------------------------------------------
// crd_ctrl: sequencing controller of the clip run detector
// Accepts samples, then on the last sample of a buffer walks through the
// run tally, up to two gain divisions and the output load.
// ----------------------------------------------------------------------------
module crd_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           last_sample_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  output crd_pkg::cmd_t  cmd_o,
  input  crd_pkg::sts_t  sts_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TALLY,
    S_DECIDE,
    S_LO_START,
    S_LO_WAIT,
    S_HI_START,
    S_HI_WAIT,
    S_FINISH
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   idle;
  logic   accept;
  logic   out_free;

  // A configuration write goes first; a sample offered with it is stalled.
  assign idle     = (state_q == S_IDLE);
  assign accept   = idle && in_valid_i && !cfg_valid_i;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd_o           = '0;
    cmd_o.step      = accept;
    cmd_o.cfg_we    = idle && cfg_valid_i;
    cmd_o.tally     = (state_q == S_TALLY);
    cmd_o.div_start = (state_q == S_LO_START) || (state_q == S_HI_START);
    cmd_o.div_hi    = (state_q == S_HI_START) || (state_q == S_HI_WAIT);
    cmd_o.load      = (state_q == S_FINISH) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept && last_sample_i) begin
            state_q <= S_TALLY;
          end
        end
        S_TALLY: begin
          if (sts_i.tally_last) begin
            state_q <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          state_q <= sts_i.need_div ? S_LO_START : S_FINISH;
        end
        S_LO_START: begin
          state_q <= S_LO_WAIT;
        end
        S_LO_WAIT: begin
          if (sts_i.div_done) begin
            state_q <= sts_i.hi_zero ? S_FINISH : S_HI_START;
          end
        end
        S_HI_START: begin
          state_q <= S_HI_WAIT;
        end
        S_HI_WAIT: begin
          if (sts_i.div_done) begin
            state_q <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase

      // A waiting result holds until its transfer; a new load replaces it.
      if (cmd_o.load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_stall_o  = !idle || cfg_valid_i;
  assign cfg_ready_o = idle;
  assign out_valid_o = out_valid_q;

endmodule

FILE: sv/clip_run_detector_top.sv
// Samples that are not last transfer back to back unless a configuration write is
// offered. A last sample is followed by a tally of each active channel, a decide state
// and, when a gain is computed, the low term and, unless the high peak is zero, the
// high term in the shared divider before the load. No sample is taken until the result
// loads, and a stalled earlier result delays that load. Asynchronous active-low reset
// loads 2 channels, float source.
// ----------------------------------------------------------------------------
// clip_run_detector_top: clip run detector
// Counts per-channel runs of overrange samples, tracks peaks and reports a
// verdict and normalizing gain at the end of each buffer.
// ----------------------------------------------------------------------------
module clip_run_detector_top #(
  parameter int MAX_CHANNELS = crd_pkg::MAX_CHANNELS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [crd_pkg::SAMPLE_W-1:0]  sample_i,
  input  logic                                 last_sample_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [crd_pkg::COUNT_W-1:0]          clipped_count_o,
  output logic signed [crd_pkg::SAMPLE_W-1:0]  peak_low_o,
  output logic [crd_pkg::PEAK_HIGH_W-1:0]      peak_high_o,
  output logic [crd_pkg::VERDICT_W-1:0]        verdict_o,
  output logic [crd_pkg::GAIN_W-1:0]           gain_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [crd_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [crd_pkg::CFG_DATA_W-1:0]       cfg_data_i
);

  crd_pkg::cmd_t cmd;
  crd_pkg::sts_t sts;

  crd_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .last_sample_i (last_sample_i),
    .in_stall_o    (in_stall_o),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cmd_o         (cmd),
    .sts_i         (sts)
  );

  crd_datapath #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .sample_i        (sample_i),
    .clipped_count_o (clipped_count_o),
    .peak_low_o      (peak_low_o),
    .peak_high_o     (peak_high_o),
    .verdict_o       (verdict_o),
    .gain_o          (gain_o)
  );

endmodule
